// ===== hw/rtl/rsfp_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rsfp_pkg
// Shared types, constants and command decode for the RS-485 frame parser.
// ----------------------------------------------------------------------------
package rsfp_pkg;

	localparam logic [7:0] SYNC_BYTE = 8'hFF;
	localparam logic [7:0] SUB_GET_CMD = 8'h01;
	localparam logic [7:0] MOD_ALL_ONES = 8'hFF;

	localparam logic [2:0] DEV_MIN = 3'd1;
	localparam logic [2:0] DEV_ARM = 3'd2;
	localparam logic [2:0] DEV_SHOOTER = 3'd3;
	localparam logic [2:0] DEV_RANGER = 3'd4;

	typedef enum logic [2:0] {
		CMD_NONE        = 3'd0,
		CMD_GET         = 3'd1,
		CMD_GET_HOLD    = 3'd2,
		CMD_FROM_HOLD   = 3'd3,
		CMD_HIGH_DOWN   = 3'd4,
		CMD_HIGH_LIFT   = 3'd5,
		CMD_SHOOT       = 3'd6,
		CMD_REPORT_DIST = 3'd7
	} cmd_t;

	typedef struct packed {
		logic [7:0] rx_byte;
	} in_item_t;

	typedef struct packed {
		logic [2:0]  device_id;
		logic [15:0] payload_length;
		logic [7:0]  first_payload;
		logic [7:0]  second_payload;
		cmd_t        command;
	} out_item_t;

	function automatic cmd_t decode_command(input logic [2:0] dev, input logic [7:0] b0,
			input logic [7:0] b1);
		cmd_t c;
		c = CMD_NONE;
		if (b0 == SUB_GET_CMD) begin
			if (dev == DEV_ARM) begin
				if (b1 >= 8'(CMD_GET) && b1 <= 8'(CMD_HIGH_LIFT)) begin
					c = cmd_t'(b1[2:0]);
				end
			end else if (dev == DEV_SHOOTER) begin
				c = CMD_SHOOT;
			end else if (dev == DEV_RANGER) begin
				c = CMD_REPORT_DIST;
			end
		end
		return c;
	endfunction

endpackage
`default_nettype wire

// ===== hw/rtl/rsfp_stream_if.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rsfp_stream_if
// Valid/ready channel carrying one item per handshake.
// ----------------------------------------------------------------------------
interface rsfp_stream_if #(
	parameter type T = logic [7:0]
);
	logic valid;
	logic ready;
	T     data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

// ===== hw/rtl/rs485_frame_parser_command_decode_unit.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rs485_frame_parser_command_decode_unit
// Hunts for FF FF framed packets, checks the mod-255 additive checksum and
// decodes the command from the device id and the first two payload bytes.
// ----------------------------------------------------------------------------
// Output: a result is registered in the cycle after its checksum byte is accepted.
// Throughput: one byte per cycle; the parser state updates once per byte.
// The byte input stalls only on a checksum byte while a result waits.
// Reset: asynchronous, active low; parser hunts for the first sync byte
// and the result register is empty.
module rs485_frame_parser_command_decode_unit (
	input  wire logic     clk,
	input  wire logic     arst_n,
	rsfp_stream_if.sink   rx,
	rsfp_stream_if.source res
);
	import rsfp_pkg::*;

	typedef enum logic [2:0] {
		PH_SYNC1,
		PH_SYNC2,
		PH_ID,
		PH_LENHI,
		PH_LENLO,
		PH_PAYLOAD,
		PH_CHECK
	} phase_t;

	phase_t      phase_q, phase_d;
	logic [15:0] sum_q, sum_d;
	logic [15:0] seen_q, seen_d;
	logic [7:0]  len_hi_q, len_hi_d;
	logic [15:0] len_q, len_d;
	logic [2:0]  dev_q, dev_d;
	logic [7:0]  cap0_q, cap0_d;
	logic [7:0]  cap1_q, cap1_d;

	logic        out_v_q;
	out_item_t   out_q;

	logic        accept;
	logic [7:0]  b;
	logic [8:0]  fold1;
	logic [7:0]  fold2;
	logic [7:0]  chk;
	logic        fire;

	assign rx.ready  = !out_v_q || res.ready || (phase_q != PH_CHECK);
	assign accept    = rx.valid && rx.ready;
	assign b         = rx.data.rx_byte;
	assign res.valid = out_v_q;
	assign res.data  = out_q;

	// 65536 = 1 mod 255, 256 = 1 mod 255: fold the sum twice
	assign fold1 = {1'b0, sum_q[15:8]} + {1'b0, sum_q[7:0]};
	assign fold2 = fold1[7:0] + {7'd0, fold1[8]};
	assign chk   = (fold2 == MOD_ALL_ONES) ? 8'd0 : fold2;

	assign fire = accept && (phase_q == PH_CHECK) && (b == chk);

	always_comb begin
		phase_d  = phase_q;
		sum_d    = sum_q;
		seen_d   = seen_q;
		len_hi_d = len_hi_q;
		len_d    = len_q;
		dev_d    = dev_q;
		cap0_d   = cap0_q;
		cap1_d   = cap1_q;
		if (accept) begin
			unique case (phase_q)
				PH_SYNC1: begin
					if (b == SYNC_BYTE) begin
						phase_d = PH_SYNC2;
						sum_d   = '0;
						seen_d  = '0;
						cap0_d  = '0;
						cap1_d  = '0;
					end
				end
				PH_SYNC2: begin
					phase_d = (b == SYNC_BYTE) ? PH_ID : PH_SYNC1;
				end
				PH_ID: begin
					if (b >= {5'd0, DEV_MIN} && b <= {5'd0, DEV_RANGER}) begin
						dev_d   = b[2:0];
						sum_d   = sum_q + {8'd0, b};
						phase_d = PH_LENHI;
					end else begin
						phase_d = PH_SYNC1;
					end
				end
				PH_LENHI: begin
					sum_d    = sum_q + {8'd0, b};
					len_hi_d = b;
					phase_d  = PH_LENLO;
				end
				PH_LENLO: begin
					sum_d   = sum_q + {8'd0, b};
					len_d   = {len_hi_q, b};
					seen_d  = '0;
					phase_d = PH_PAYLOAD;
				end
				PH_PAYLOAD: begin
					sum_d = sum_q + {8'd0, b};
					if (seen_q == 16'd0) begin
						cap0_d = b;
					end else if (seen_q == 16'd1) begin
						cap1_d = b;
					end
					if (({1'b0, seen_q} + 17'd1) >= {1'b0, len_q}) begin
						phase_d = PH_CHECK;
					end
					if (seen_q != 16'hFFFF) begin
						seen_d = seen_q + 16'd1;
					end
				end
				PH_CHECK: begin
					sum_d   = '0;
					phase_d = PH_SYNC1;
				end
				default: begin
					phase_d = PH_SYNC1;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= PH_SYNC1;
			sum_q    <= '0;
			seen_q   <= '0;
			len_hi_q <= '0;
			len_q    <= '0;
			dev_q    <= '0;
			cap0_q   <= '0;
			cap1_q   <= '0;
			out_v_q  <= 1'b0;
			out_q    <= '0;
		end else begin
			phase_q  <= phase_d;
			sum_q    <= sum_d;
			seen_q   <= seen_d;
			len_hi_q <= len_hi_d;
			len_q    <= len_d;
			dev_q    <= dev_d;
			cap0_q   <= cap0_d;
			cap1_q   <= cap1_d;
			if (!out_v_q || res.ready) begin
				out_v_q <= fire;
			end
			if (fire) begin
				out_q.device_id      <= dev_q;
				out_q.payload_length <= len_q;
				out_q.first_payload  <= cap0_q;
				out_q.second_payload <= cap1_q;
				out_q.command        <= decode_command(dev_q, cap0_q, cap1_q);
			end
		end
	end

endmodule
`default_nettype wire

// ===== hw/rtl/rsfp_checker.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rsfp_checker
// Port-level checks for the frame parser, bound to the top level.
// ----------------------------------------------------------------------------
module rsfp_checker (
	input wire logic                clk,
	input wire logic                arst_n,
	input wire logic                res_valid,
	input wire logic                res_ready,
	input wire rsfp_pkg::out_item_t res_data
);
	import rsfp_pkg::*;

	a_res_hold_valid: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> res_valid)
		else $error("result item dropped while stalled");

	a_res_hold_data: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> $stable(res_data))
		else $error("result item changed while stalled");

	a_dev_range: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> (res_data.device_id >= DEV_MIN && res_data.device_id <= DEV_RANGER))
		else $error("device id out of range");

	a_cmd_needs_sub: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && (res_data.command != CMD_NONE) |-> (res_data.first_payload == SUB_GET_CMD))
		else $error("command decoded without sub-command byte");

	a_cmd_device: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && (res_data.command == CMD_SHOOT) |-> (res_data.device_id == DEV_SHOOTER))
		else $error("shoot command from wrong device");

endmodule

bind rs485_frame_parser_command_decode_unit rsfp_checker u_rsfp_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.res_valid (res.valid),
	.res_ready (res.ready),
	.res_data  (res.data)
);
`default_nettype wire
